// ===== hw/rtl/kwm_pkg.sv =====
// Shared types, widths and codes for the k-way sorted merge.
`timescale 1ns / 1ps

package kwm_pkg;

  localparam int VALUE_W  = 32;
  localparam int STREAM_W = 3;
  localparam int ACTIVE_W = 4;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 4'd8;

  // Source select for a chain cell's next contents
  typedef logic [1:0] sel_t;
  localparam sel_t SEL_SELF = 2'd0;
  localparam sel_t SEL_PREV = 2'd1;
  localparam sel_t SEL_NEXT = 2'd2;
  localparam sel_t SEL_NEW  = 2'd3;

  typedef struct packed {
    logic                valid;
    logic [VALUE_W-1:0]  value;
    logic [STREAM_W-1:0] stream;
  } slot_t;

  typedef struct packed {
    logic load;
    logic clear;
    sel_t sel;
  } cell_ctl_t;

  // Stream 0 is always in use; others only below the configured count.
  function automatic logic stream_active(input logic [STREAM_W-1:0] stream,
                                         input logic [ACTIVE_W-1:0] act);
    return (stream == '0) || ({1'b0, stream} < act);
  endfunction

endpackage

// ===== hw/rtl/kwm_if.sv =====
// Valid/ready channel interfaces for the merge input and output beats.
`timescale 1ns / 1ps

interface kwm_in_if import kwm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STREAM_W-1:0] stream_index;
  logic [VALUE_W-1:0]  element_value;
  logic                end_of_stream;

  modport source (output valid, output stream_index, output element_value,
                  output end_of_stream, input ready);
  modport sink   (input valid, input stream_index, input element_value,
                  input end_of_stream, output ready);
endinterface

interface kwm_out_if import kwm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [VALUE_W-1:0]  merged_value;
  logic [STREAM_W-1:0] source_stream;
  logic                done_res;

  modport source (output valid, output merged_value, output source_stream,
                  output done_res, input ready);
  modport sink   (input valid, input merged_value, input source_stream,
                  input done_res, output ready);
endinterface

// ===== hw/rtl/kwm_cell.sv =====
// One cell of the sorted head chain: holds a head and shifts with its neighbors.
`timescale 1ns / 1ps

module kwm_cell import kwm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cell_ctl_t ctl,
  input  slot_t     prev,
  input  slot_t     next,
  input  slot_t     fresh,
  output slot_t     slot,
  output logic      after_new
);

  slot_t slot_next;

  always_comb begin
    case (ctl.sel)
      SEL_PREV: slot_next = prev;
      SEL_NEXT: slot_next = next;
      SEL_NEW:  slot_next = fresh;
      default:  slot_next = slot;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      slot.value  <= slot_next.value;
      slot.stream <= slot_next.stream;
    end
    if (rst || ctl.clear) begin
      slot.valid <= 1'b0;
    end else if (ctl.load) begin
      slot.valid <= slot_next.valid;
    end
  end

  // Key order is (value, stream); this head sorts after the incoming one
  assign after_new = slot.valid &&
                     (($signed(slot.value) > $signed(fresh.value)) ||
                      ((slot.value == fresh.value) && (slot.stream > fresh.stream)));

endmodule

// ===== hw/rtl/k_way_sorted_merge.sv =====
// Top level of the k-way sorted merge: stream flags, chain control, output register.
`timescale 1ns / 1ps

// Merges up to STREAMS ascending streams into one ascending output. Heads sit in
// a chain of STREAMS cells kept sorted by (value, stream); an input beat inserts
// its head and, once every active stream holds a head or has ended, the first
// active entry of the chain is removed and sent out, all in the cycle the beat
// is accepted. One input beat per clock is sustained: the insert/remove over the
// cell chain is combinational, and an output register lets the next beat in
// while the previous result waits, so input stalls only while a result is held
// by output backpressure. A result appears in the cycle after its beat. When all
// active streams have ended a done beat (value 0, stream 0) is sent and all heads
// and flags clear. The user must write active_streams only while idle; not enforced.
module k_way_sorted_merge import kwm_pkg::*; #(
  parameter int STREAMS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [ACTIVE_W-1:0] cfg_wr_data,
  kwm_in_if.sink              in_ch,
  kwm_out_if.source           out_ch
);

  logic [ACTIVE_W-1:0] active_streams;
  logic [STREAMS-1:0]  present;
  logic [STREAMS-1:0]  ended;

  slot_t               slots [STREAMS];
  logic [STREAMS-1:0]  after_new;
  cell_ctl_t           ctl [STREAMS];
  slot_t               fresh;

  logic                in_fire;
  logic [STREAMS-1:0]  act_mask;
  logic [STREAMS-1:0]  take;
  logic                insert;
  logic [STREAMS-1:0]  present_ins;
  logic [STREAMS-1:0]  ended_ins;
  logic                ready_chk;
  logic                all_end;
  logic                do_emit;
  logic                do_done;

  logic [STREAMS:0]    bp_ext;   // cell j sits ahead of the insert point
  logic [STREAMS:0]    bp_sh;
  slot_t               slot_ext [STREAMS+1];
  slot_t               slot_sh  [STREAMS+1];
  slot_t               ins      [STREAMS+1];
  logic [STREAMS-1:0]  hit;
  logic [STREAMS-1:0]  keep;
  logic [STREAMS-1:0]  keep_eff;
  slot_t               emit_slot;
  logic [STREAMS-1:0]  emit_mask;

  logic                out_valid;
  logic [VALUE_W-1:0]  merged_value;
  logic [STREAM_W-1:0] source_stream;
  logic                done_res;

  assign in_fire     = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !out_valid || out_ch.ready;

  // Stream bookkeeping and readiness after the beat is applied
  always_comb begin
    for (int i = 0; i < STREAMS; i++) begin
      act_mask[i] = (i == 0) || (32'(i) < 32'(active_streams));
      take[i]     = (32'(in_ch.stream_index) == i) && act_mask[i] &&
                    !present[i] && !ended[i];
    end
    insert      = (|take) && !in_ch.end_of_stream;
    present_ins = present | (insert ? take : '0);
    ended_ins   = ended | (in_ch.end_of_stream ? take : '0);
    ready_chk   = &((present_ins | ended_ins) | ~act_mask);
    all_end     = &(ended_ins | ~act_mask);
    do_done     = in_fire && ready_chk && all_end;
    do_emit     = in_fire && ready_chk && !all_end;
  end

  assign fresh.valid  = insert;
  assign fresh.value  = in_ch.element_value;
  assign fresh.stream = in_ch.stream_index;

  // Chain as it would look after the insert, then the first active entry
  always_comb begin
    bp_ext[STREAMS]   = 1'b0;
    bp_sh[0]          = 1'b1;
    slot_ext[STREAMS] = '0;
    slot_sh[0]        = '0;
    for (int j = 0; j < STREAMS; j++) begin
      bp_ext[j]     = insert ? (slots[j].valid && !after_new[j]) : 1'b1;
      bp_sh[j+1]    = bp_ext[j];
      slot_ext[j]   = slots[j];
      slot_sh[j+1]  = slots[j];
    end
    for (int j = 0; j <= STREAMS; j++) begin
      if (bp_ext[j]) begin
        ins[j] = slot_ext[j];
      end else if (bp_sh[j]) begin
        ins[j] = fresh;
      end else begin
        ins[j] = slot_sh[j];
      end
    end
    for (int j = 0; j < STREAMS; j++) begin
      hit[j] = ins[j].valid && stream_active(ins[j].stream, active_streams);
    end
    keep[0] = 1'b1;
    for (int j = 1; j < STREAMS; j++) begin
      keep[j] = keep[j-1] && !hit[j-1];
    end
    // the removed cell itself also shifts up
    keep_eff  = do_emit ? (keep & ~hit) : '1;
    emit_slot = '0;
    for (int j = 0; j < STREAMS; j++) begin
      if (keep[j] && hit[j]) begin
        emit_slot = ins[j];
      end
    end
    for (int i = 0; i < STREAMS; i++) begin
      emit_mask[i] = do_emit && (32'(emit_slot.stream) == i);
    end
  end

  // Per-cell source select: ahead of the removal point take the inserted view,
  // at and behind it take the inserted view one place further down.
  always_comb begin
    for (int j = 0; j < STREAMS; j++) begin
      ctl[j].load  = in_fire;
      ctl[j].clear = do_done;
      if (keep_eff[j]) begin
        if (bp_ext[j]) begin
          ctl[j].sel = SEL_SELF;
        end else if (bp_sh[j]) begin
          ctl[j].sel = SEL_NEW;
        end else begin
          ctl[j].sel = SEL_PREV;
        end
      end else begin
        if (bp_ext[j+1]) begin
          ctl[j].sel = SEL_NEXT;
        end else if (bp_sh[j+1]) begin
          ctl[j].sel = SEL_NEW;
        end else begin
          ctl[j].sel = SEL_SELF;
        end
      end
    end
  end

  for (genvar j = 0; j < STREAMS; j++) begin : g_cell
    kwm_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl[j]),
      .prev      (slot_sh[j]),
      .next      (slot_ext[j+1]),
      .fresh     (fresh),
      .slot      (slots[j]),
      .after_new (after_new[j])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_streams <= ACTIVE_RESET;
    end else if (cfg_wr_en) begin
      active_streams <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      present <= '0;
      ended   <= '0;
    end else if (in_fire) begin
      if (do_done) begin
        present <= '0;
        ended   <= '0;
      end else begin
        present <= present_ins & ~emit_mask;
        ended   <= ended_ins;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (do_emit || do_done) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_emit || do_done) begin
      merged_value  <= do_done ? '0 : emit_slot.value;
      source_stream <= do_done ? '0 : emit_slot.stream;
      done_res      <= do_done;
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.merged_value  = merged_value;
  assign out_ch.source_stream = source_stream;
  assign out_ch.done_res      = done_res;

endmodule

// ===== hw/rtl/kwm_checker.sv =====
// Port-level checks for the k-way sorted merge, bound to the top level.
`timescale 1ns / 1ps

module kwm_checker import kwm_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [VALUE_W-1:0]  merged_value,
  input logic [STREAM_W-1:0] source_stream,
  input logic                done_res
);

  // A held result keeps its beat
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(merged_value) &&
                                $stable(source_stream) && $stable(done_res))
    else $error("output beat changed while stalled");

  a_done_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> (merged_value == '0) && (source_stream == '0))
    else $error("done beat carries nonzero payload");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  // A blocked result must block the input side, or a result would be lost
  a_block_on_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while result is stalled");

  // A result only shows up after an accepted input beat
  a_out_from_beat: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("output beat without an input beat");

endmodule

bind k_way_sorted_merge kwm_checker u_kwm_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .merged_value  (out_ch.merged_value),
  .source_stream (out_ch.source_stream),
  .done_res      (out_ch.done_res)
);

// ===== verif/kwm_merge_checker.sv =====
// Checker for the k-way merge: predicts each merged beat and compares it field by field.
`timescale 1ns / 1ps

module kwm_merge_checker import kwm_pkg::*; #(
  parameter int STREAMS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [ACTIVE_W-1:0] cfg_wr_data,
  kwm_in_if                   in_ch,
  kwm_out_if                  out_ch,
  output int                  mismatches,
  output int                  pending,
  output logic [STREAMS-1:0]  waiting_mask,
  output int                  applied_cnt,
  output int                  ignored_cnt,
  output int                  result_cnt,
  output int                  done_cnt
);

  typedef struct packed {
    logic [VALUE_W-1:0]  value;
    logic [STREAM_W-1:0] stream;
    logic                done;
  } merge_beat_t;

  logic [VALUE_W-1:0]  head_val [STREAMS];
  logic [STREAMS-1:0]  head_full;
  logic [STREAMS-1:0]  ended;
  logic [ACTIVE_W-1:0] active_reg;
  merge_beat_t         merge_fifo[$];

  initial begin
    mismatches   = 0;
    pending      = 0;
    waiting_mask = '0;
    applied_cnt  = 0;
    ignored_cnt  = 0;
    result_cnt   = 0;
    done_cnt     = 0;
    head_full    = '0;
    ended        = '0;
    active_reg   = ACTIVE_RESET;
  end

  // A count of 0 still keeps stream 0 in use; anything above STREAMS saturates.
  function automatic int lanes_in_use();
    if (active_reg == '0) return 1;
    if (active_reg > STREAMS) return STREAMS;
    return int'(active_reg);
  endfunction

  task automatic advance_merge(input logic [STREAM_W-1:0] s, input logic [VALUE_W-1:0] v,
                               input logic eos);
    int          n;
    int          best;
    bit          stalled;
    bit          all_ended;
    bit          have_head;
    merge_beat_t r;
    n         = lanes_in_use();
    best      = 0;
    stalled   = 1'b0;
    all_ended = 1'b1;
    have_head = 1'b0;
    if (int'(s) < n && !head_full[s] && !ended[s]) begin
      applied_cnt++;
      if (eos) begin
        ended[s] = 1'b1;
      end else begin
        head_val[s]  = v;
        head_full[s] = 1'b1;
      end
    end else begin
      ignored_cnt++;
    end
    // readiness runs every beat, even an ignored one
    for (int i = 0; i < n; i++) begin
      if (!head_full[i] && !ended[i]) stalled = 1'b1;
      if (!ended[i]) all_ended = 1'b0;
      if (head_full[i] && (!have_head || $signed(head_val[i]) < $signed(head_val[best]))) begin
        best      = i;
        have_head = 1'b1;
      end
    end
    if (!stalled) begin
      if (all_ended || !have_head) begin
        r.value  = '0;
        r.stream = '0;
        r.done   = 1'b1;
        head_full = '0;
        ended     = '0;
        done_cnt++;
      end else begin
        r.value  = head_val[best];
        r.stream = STREAM_W'(best);
        r.done   = 1'b0;
        head_full[best] = 1'b0;
      end
      merge_fifo = {merge_fifo, r};
    end
  endtask

  always @(posedge clk) begin : watch
    merge_beat_t want;
    if (rst) begin
      head_full  = '0;
      ended      = '0;
      active_reg = ACTIVE_RESET;
      merge_fifo.delete();
    end else begin
      if (cfg_wr_en) active_reg = cfg_wr_data;
      if (in_ch.valid && in_ch.ready)
        advance_merge(in_ch.stream_index, in_ch.element_value, in_ch.end_of_stream);
      if (out_ch.valid && out_ch.ready) begin
        result_cnt++;
        if (merge_fifo.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected merged beat value %0d stream %0d done %0b", $time,
                     $signed(out_ch.merged_value), out_ch.source_stream, out_ch.done_res);
        end else begin
          want = merge_fifo.pop_front();
          if (out_ch.merged_value !== want.value || out_ch.source_stream !== want.stream ||
              out_ch.done_res !== want.done) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"%0t: merged beat mismatch: want value %0d stream %0d done %0b,",
                        " got value %0d stream %0d done %0b"},
                       $time, $signed(want.value), want.stream, want.done,
                       $signed(out_ch.merged_value), out_ch.source_stream, out_ch.done_res);
          end
        end
      end
    end
    pending = merge_fifo.size();
    for (int i = 0; i < STREAMS; i++)
      waiting_mask[i] = (i < lanes_in_use()) && !head_full[i] && !ended[i];
  end

endmodule

// ===== verif/tb.sv =====
// Testbench top for the k-way merge: clock, reset, stimulus, backpressure and verdict.
`timescale 1ns / 1ps

module tb;
  import kwm_pkg::*;

  localparam int STREAMS = 8;
  localparam int PHASES  = 12;
  localparam logic [ACTIVE_W-1:0] PHASE_ACTIVE [PHASES] =
    '{4'd3, 4'd8, 4'd1, 4'd15, 4'd5, 4'd0, 4'd2, 4'd9, 4'd7, 4'd4, 4'd6, 4'd8};

  logic                clk;
  logic                rst;
  logic                cfg_wr_en;
  logic [ACTIVE_W-1:0] cfg_wr_data;

  int                  mismatches;
  int                  pending;
  logic [STREAMS-1:0]  waiting_mask;
  int                  applied_cnt;
  int                  ignored_cnt;
  int                  result_cnt;
  int                  done_cnt;

  bit                  idle_on;
  int                  lanes;
  logic [VALUE_W-1:0]  lane_elems [STREAMS][$];

  kwm_in_if  in_ch ();
  kwm_out_if out_ch ();

  k_way_sorted_merge #(.STREAMS(STREAMS)) dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  kwm_merge_checker #(.STREAMS(STREAMS)) chk (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .mismatches   (mismatches),
    .pending      (pending),
    .waiting_mask (waiting_mask),
    .applied_cnt  (applied_cnt),
    .ignored_cnt  (ignored_cnt),
    .result_cnt   (result_cnt),
    .done_cnt     (done_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // Output backpressure: ready drops in random stall bursts while idling is on.
  initial begin : out_pacing
    int hold;
    hold = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
      end else if (!idle_on || $urandom_range(0, 2) != 0) begin
        out_ch.ready = 1'b1;
        hold = $urandom_range(0, 15);
      end else begin
        out_ch.ready = 1'b0;
        hold = $urandom_range(0, 10);
      end
    end
  end

  // Starts and ends at a falling edge; holds the beat until it is taken.
  task automatic send_beat(input logic [STREAM_W-1:0] s, input logic [VALUE_W-1:0] v,
                           input logic eos);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_ch.stream_index  = s;
    in_ch.element_value = v;
    in_ch.end_of_stream = eos;
    in_ch.valid         = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Drain every predicted beat, then let the clock run on for a beat that produced nothing.
  task automatic settle();
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_active(input logic [ACTIVE_W-1:0] v);
    settle();
    cfg_wr_en   = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    lanes = (v == '0) ? 1 : ((v > STREAMS) ? STREAMS : int'(v));
  endtask

  // One merge pass: ascending lists per active stream, fed only to waiting
  // streams, with some noise beats mixed in; ends on the predicted done beat.
  task automatic run_round();
    int                 mode;
    int                 len;
    int                 s;
    int                 mark;
    int unsigned        step;
    longint             cur;
    logic [STREAMS-1:0] mask;
    mode = $urandom_range(0, 2);
    for (int i = 0; i < STREAMS; i++) begin
      lane_elems[i].delete();
      if (i < lanes) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 14) : $urandom_range(0, 4);
        case (mode)
          0: begin
            cur  = longint'($signed(32'h8000_0000));
            step = 32'h4000_0000;
          end
          1: begin
            cur  = -3;
            step = 1;
          end
          default: begin
            cur  = longint'($signed($urandom));
            step = 5000;
          end
        endcase
        repeat (len) begin
          cur += $urandom_range(0, step);
          if (cur > 64'sd2147483647) cur = 64'sd2147483647;
          lane_elems[i] = {lane_elems[i], cur[31:0]};
        end
      end
    end
    mark = done_cnt;
    while (done_cnt == mark) begin
      mask = waiting_mask;
      if (mask == '0 || $urandom_range(0, 9) == 0) begin
        send_beat(STREAM_W'($urandom_range(0, STREAMS - 1)), $urandom,
                  1'($urandom_range(0, 1)));
      end else begin
        s = $urandom_range(0, STREAMS - 1);
        while (!mask[s]) s = (s + 1) % STREAMS;
        if (lane_elems[s].size() != 0)
          send_beat(STREAM_W'(s), lane_elems[s].pop_front(), 1'b0);
        else
          send_beat(STREAM_W'(s), $urandom, 1'b1);
      end
      if ($urandom_range(0, 149) == 0) settle();
    end
  endtask

  initial begin : stimulus
    int target;
    rst                 = 1'b1;
    cfg_wr_en           = 1'b0;
    cfg_wr_data         = '0;
    in_ch.valid         = 1'b0;
    in_ch.stream_index  = '0;
    in_ch.element_value = '0;
    in_ch.end_of_stream = 1'b0;
    idle_on             = 1'b1;
    lanes               = STREAMS;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // two streams: extremes, ties, ignored beats for held, ended and unused streams
    write_active(4'd2);
    send_beat(3'd0, 32'h7fff_ffff, 1'b0);
    send_beat(3'd0, 32'd5, 1'b0);
    send_beat(3'd5, 32'd1, 1'b0);
    send_beat(3'd1, 32'h8000_0000, 1'b0);
    send_beat(3'd1, 32'h7fff_ffff, 1'b0);
    send_beat(3'd0, 32'h0, 1'b1);
    send_beat(3'd0, 32'd3, 1'b0);
    send_beat(3'd1, 32'hffff_ffff, 1'b0);
    send_beat(3'd1, 32'h0, 1'b1);

    // shrinking the count mid-merge lets an ignored beat trigger an emission
    write_active(4'd8);
    send_beat(3'd0, 32'd10, 1'b0);
    send_beat(3'd1, -32'sd7, 1'b0);
    send_beat(3'd2, 32'd10, 1'b0);
    write_active(4'd3);
    send_beat(3'd6, 32'h0, 1'b0);
    send_beat(3'd1, -32'sd20, 1'b0);
    send_beat(3'd1, 32'h0, 1'b1);
    send_beat(3'd0, 32'h0, 1'b1);
    send_beat(3'd2, 32'h0, 1'b1);

    // count of zero behaves as one stream
    write_active(4'd0);
    send_beat(3'd3, 32'd4, 1'b0);
    send_beat(3'd0, -32'sd100, 1'b0);
    send_beat(3'd0, 32'h0, 1'b1);

    for (int p = 0; p < PHASES; p++) begin
      write_active(PHASE_ACTIVE[p]);
      idle_on = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
      target  = applied_cnt + 150;
      while (applied_cnt < target) run_round();
    end

    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    $display("Merge run: %0d applied input beats, %0d ignored, over %0d stream-count settings.",
             applied_cnt, ignored_cnt, PHASES + 4);
    $display("Checked %0d output beats, %0d of them end-of-merge markers.",
             result_cnt, done_cnt);
    if (mismatches == 0 && pending == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/kwm_pkg.sv
hw/rtl/kwm_if.sv
hw/rtl/kwm_cell.sv
hw/rtl/k_way_sorted_merge.sv
hw/rtl/kwm_checker.sv
verif/kwm_merge_checker.sv
verif/tb.sv
